[hdl/jsu_pkg.sv]
`timescale 1ns / 1ps

package jsu_pkg;

   // Decoder phases of the string being read.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_HEX,
      PH_WAIT_BS,
      PH_WAIT_U
   } phase_type;

   // Result kinds as they appear on the result channel.
   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_QUOTE     = 2'd1,
      KIND_NUL       = 2'd2,
      KIND_BAD_START = 2'd3
   } kind_type;

   // Characters the decoder reacts to.
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_0         = 8'h30;
   localparam logic [7:0] CH_9         = 8'h39;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;

   // Control codes the short escapes stand for.
   localparam logic [7:0] CODE_BS = 8'h08;
   localparam logic [7:0] CODE_FF = 8'h0C;
   localparam logic [7:0] CODE_LF = 8'h0A;
   localparam logic [7:0] CODE_CR = 8'h0D;
   localparam logic [7:0] CODE_HT = 8'h09;

   // UTF-16 surrogate ranges and the supplementary plane offset.
   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   // UTF-8 length limits and lead marks.
   localparam logic [20:0] LIMIT_1 = 21'h80;
   localparam logic [20:0] LIMIT_2 = 21'h800;
   localparam logic [20:0] LIMIT_3 = 21'h10000;
   localparam logic [7:0]  LEAD_2  = 8'hC0;
   localparam logic [7:0]  LEAD_3  = 8'hE0;
   localparam logic [7:0]  LEAD_4  = 8'hF0;
   localparam logic [7:0]  CONT    = 8'h80;

   // One queued job: up to four result bytes, index of the last one, kind.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      kind_type        kind;
   } job_type;

   // Write side of the job queue.
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_wr_type;

   // Status of the job queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

[hdl/jsu_if.sv]
`timescale 1ns / 1ps

// Input byte channel.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_req;

   modport source (output valid, output in_byte, output start_req, input ready);
   modport sink (input valid, input in_byte, input start_req, output ready);
endinterface

// Decoded result channel.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       last;

   modport source (output valid, output out_byte, output kind, output last, input ready);
   modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

[hdl/json_string_unescape_utf8_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Payload                    Beat
// req_bus   in   in_byte[8], start_req[1]   one source byte
// rsp_bus   out  out_byte[8], kind[2], last  one decoded result
//
// One source byte is taken per cycle while the job queue has room.
// A byte yields zero to four result beats, delivered one per cycle while rsp_bus
// is ready; the job's last_idx from the encoder sets that figure, and the back
// end plays out a job while the front keeps decoding into the queue.
// Synchronous reset empties the queue and returns the decoder to idle.
// req_bus.ready falls only when QUEUE_DEPTH jobs wait in the queue.
module json_string_unescape_utf8_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic       clock,
   input logic       reset,
   jsu_req_if.sink   req_bus,
   jsu_rsp_if.source rsp_bus
);

   jsu_pkg::queue_wr_type   q_wr;
   jsu_pkg::queue_stat_type q_stat;
   jsu_pkg::job_type        q_job;
   jsu_pkg::phase_type      phase;
   logic                    q_pop;

   // Byte decoder.
   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_stat (q_stat),
      .q_wr   (q_wr),
      .phase  (phase)
   );

   // Jobs waiting for the output side.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (q_wr),
      .pop    (q_pop),
      .rd_job (q_job),
      .stat   (q_stat)
   );

   // Result sequencer.
   jsu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_job  (q_job),
      .q_stat (q_stat),
      .pop    (q_pop),
      .rsp    (rsp_bus)
   );

   // An accepted opening quote always opens the string body.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.start_req &&
       ((req_bus.in_byte == jsu_pkg::CH_DQUOTE) || (req_bus.in_byte == jsu_pkg::CH_SQUOTE)))
      |=> (phase == jsu_pkg::PH_BODY))
      else $error("opening quote did not open the string");

   // A NUL inside an open string closes it.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !req_bus.start_req &&
       (req_bus.in_byte == jsu_pkg::CH_NUL) && (phase != jsu_pkg::PH_IDLE))
      |=> (phase == jsu_pkg::PH_IDLE))
      else $error("NUL byte left the string open");

   // Status results (quote, NUL and bad start) are single beats.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.kind != jsu_pkg::KIND_DATA)) |-> rsp_bus.last)
      else $error("status result not marked last");

   // The queue is never full and empty at once.
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue status inconsistent");

endmodule

[hdl/jsu_front.sv]
`timescale 1ns / 1ps

module jsu_front (
   input  logic                   clock,
   input  logic                   reset,
   jsu_req_if.sink                req,
   input  jsu_pkg::queue_stat_type q_stat,
   output jsu_pkg::queue_wr_type  q_wr,
   output jsu_pkg::phase_type     phase
);

   // Decoder state.
   jsu_pkg::phase_type phase_ff, phase_in;
   logic        single_ff, single_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        bad_ff, bad_in;
   logic [9:0]  high_ff, high_in;
   logic        pair_ff, pair_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  quote;
   logic        quote_any;
   logic        is_body, is_esc, is_hex;
   logic        nul_end, close;
   logic        dig_ok;
   logic [3:0]  dig;
   logic [15:0] acc_new;
   logic        bad_new;
   logic        hex_done;
   logic [15:0] v;
   logic        v_high, v_low;
   logic        single_ok, pair_ok, high_start;
   logic [20:0] cp;
   logic [7:0]  esc_char;

   // UTF-8 encoding of one code point into a job.
   function automatic jsu_pkg::job_type encode(input logic [20:0] c);
      jsu_pkg::job_type j;
      j = '0;
      j.kind = jsu_pkg::KIND_DATA;
      if (c < jsu_pkg::LIMIT_1) begin
         j.bytes[0] = c[7:0];
         j.last_idx = 2'd0;
      end else if (c < jsu_pkg::LIMIT_2) begin
         j.bytes[0] = {3'b000, c[10:6]} | jsu_pkg::LEAD_2;
         j.bytes[1] = {2'b00, c[5:0]} | jsu_pkg::CONT;
         j.last_idx = 2'd1;
      end else if (c < jsu_pkg::LIMIT_3) begin
         j.bytes[0] = {4'b0000, c[15:12]} | jsu_pkg::LEAD_3;
         j.bytes[1] = {2'b00, c[11:6]} | jsu_pkg::CONT;
         j.bytes[2] = {2'b00, c[5:0]} | jsu_pkg::CONT;
         j.last_idx = 2'd2;
      end else begin
         j.bytes[0] = {5'b00000, c[20:18]} | jsu_pkg::LEAD_4;
         j.bytes[1] = {2'b00, c[17:12]} | jsu_pkg::CONT;
         j.bytes[2] = {2'b00, c[11:6]} | jsu_pkg::CONT;
         j.bytes[3] = {2'b00, c[5:0]} | jsu_pkg::CONT;
         j.last_idx = 2'd3;
      end
      return j;
   endfunction

   // A byte is taken whenever the queue has room for its job.
   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign phase     = phase_ff;

   // Classification of the incoming byte.
   always_comb begin
      quote     = single_ff ? jsu_pkg::CH_SQUOTE : jsu_pkg::CH_DQUOTE;
      quote_any = (b == jsu_pkg::CH_DQUOTE) || (b == jsu_pkg::CH_SQUOTE);
      is_body   = !req.start_req && ((phase_ff == jsu_pkg::PH_BODY) ||
                  ((phase_ff == jsu_pkg::PH_WAIT_BS) && (b != jsu_pkg::CH_BACKSLASH)));
      is_esc    = !req.start_req && ((phase_ff == jsu_pkg::PH_ESC) ||
                  ((phase_ff == jsu_pkg::PH_WAIT_U) && (b != jsu_pkg::CH_U)));
      is_hex    = !req.start_req && (phase_ff == jsu_pkg::PH_HEX);
      nul_end   = (is_body || is_esc || is_hex) && (b == jsu_pkg::CH_NUL);
      close     = is_body && (b == quote);

      dig_ok = 1'b1;
      dig    = 4'd0;
      if (b inside {[jsu_pkg::CH_0 : jsu_pkg::CH_9]}) begin
         dig = 4'(b - jsu_pkg::CH_0);
      end else if (b inside {[jsu_pkg::CH_UPPER_A : jsu_pkg::CH_UPPER_F]}) begin
         dig = 4'(b - jsu_pkg::CH_UPPER_A + 8'd10);
      end else if (b inside {[jsu_pkg::CH_LOWER_A : jsu_pkg::CH_LOWER_F]}) begin
         dig = 4'(b - jsu_pkg::CH_LOWER_A + 8'd10);
      end else begin
         dig_ok = 1'b0;
      end

      acc_new  = {acc_ff[11:0], dig};
      bad_new  = bad_ff || !dig_ok;
      hex_done = is_hex && (b != jsu_pkg::CH_NUL) && (cnt_ff == 2'd3);
      v        = bad_new ? 16'd0 : acc_new;
      v_high   = (v >= jsu_pkg::HIGH_FIRST) && (v <= jsu_pkg::HIGH_LAST);
      v_low    = (v >= jsu_pkg::LOW_FIRST) && (v <= jsu_pkg::LOW_LAST);

      single_ok  = !pair_ff && (v != 16'd0) && !v_low && !v_high;
      high_start = !pair_ff && v_high;
      pair_ok    = pair_ff && v_low;
      cp         = pair_ok ? (jsu_pkg::SUPP_BASE + {1'b0, high_ff, v[9:0]}) : {5'b0, v};

      case (b)
         jsu_pkg::CH_B: esc_char = jsu_pkg::CODE_BS;
         jsu_pkg::CH_F: esc_char = jsu_pkg::CODE_FF;
         jsu_pkg::CH_N: esc_char = jsu_pkg::CODE_LF;
         jsu_pkg::CH_R: esc_char = jsu_pkg::CODE_CR;
         jsu_pkg::CH_T: esc_char = jsu_pkg::CODE_HT;
         default:       esc_char = b;
      endcase
   end

   // Next state of the decoder.
   always_comb begin
      phase_in  = phase_ff;
      single_in = single_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      bad_in    = bad_ff;
      high_in   = high_ff;
      pair_in   = pair_ff;
      if (req.start_req) begin
         acc_in  = '0;
         cnt_in  = '0;
         bad_in  = 1'b0;
         pair_in = 1'b0;
         if (quote_any) begin
            single_in = (b == jsu_pkg::CH_SQUOTE);
            phase_in  = jsu_pkg::PH_BODY;
         end else begin
            phase_in = jsu_pkg::PH_IDLE;
         end
      end else begin
         case (phase_ff)
            jsu_pkg::PH_IDLE: begin
               phase_in = jsu_pkg::PH_IDLE;
            end
            jsu_pkg::PH_BODY, jsu_pkg::PH_WAIT_BS: begin
               if ((phase_ff == jsu_pkg::PH_WAIT_BS) && (b == jsu_pkg::CH_BACKSLASH)) begin
                  phase_in = jsu_pkg::PH_WAIT_U;
               end else if ((b == quote) || (b == jsu_pkg::CH_NUL)) begin
                  phase_in = jsu_pkg::PH_IDLE;
                  pair_in  = 1'b0;
               end else if (b == jsu_pkg::CH_BACKSLASH) begin
                  phase_in = jsu_pkg::PH_ESC;
               end else begin
                  phase_in = jsu_pkg::PH_BODY;
               end
            end
            jsu_pkg::PH_ESC, jsu_pkg::PH_WAIT_U: begin
               if (b == jsu_pkg::CH_NUL) begin
                  phase_in = jsu_pkg::PH_IDLE;
                  pair_in  = 1'b0;
               end else if (b == jsu_pkg::CH_U) begin
                  phase_in = jsu_pkg::PH_HEX;
                  acc_in   = '0;
                  cnt_in   = '0;
                  bad_in   = 1'b0;
                  pair_in  = (phase_ff == jsu_pkg::PH_WAIT_U);
               end else begin
                  phase_in = jsu_pkg::PH_BODY;
               end
            end
            jsu_pkg::PH_HEX: begin
               if (b == jsu_pkg::CH_NUL) begin
                  phase_in = jsu_pkg::PH_IDLE;
                  pair_in  = 1'b0;
               end else begin
                  acc_in = acc_new;
                  bad_in = bad_new;
                  if (cnt_ff != 2'd3) begin
                     cnt_in = cnt_ff + 2'd1;
                  end else begin
                     cnt_in   = '0;
                     pair_in  = 1'b0;
                     phase_in = high_start ? jsu_pkg::PH_WAIT_BS : jsu_pkg::PH_BODY;
                     if (high_start) begin
                        high_in = v[9:0];
                     end
                  end
               end
            end
            default: begin
               phase_in = jsu_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Job for the back end, if this byte produces any result.
   always_comb begin
      q_wr          = '0;
      q_wr.job.kind = jsu_pkg::KIND_DATA;
      if (req.start_req && !quote_any) begin
         q_wr.valid    = 1'b1;
         q_wr.job.kind = jsu_pkg::KIND_BAD_START;
      end else if (nul_end) begin
         q_wr.valid    = 1'b1;
         q_wr.job.kind = jsu_pkg::KIND_NUL;
      end else if (close) begin
         q_wr.valid    = 1'b1;
         q_wr.job.kind = jsu_pkg::KIND_QUOTE;
      end else if (is_body && (b != jsu_pkg::CH_BACKSLASH)) begin
         q_wr.valid        = 1'b1;
         q_wr.job.bytes[0] = b;
      end else if (is_esc && (b != jsu_pkg::CH_U)) begin
         q_wr.valid        = 1'b1;
         q_wr.job.bytes[0] = esc_char;
      end else if (hex_done && (single_ok || pair_ok)) begin
         q_wr.valid = 1'b1;
         q_wr.job   = encode(cp);
      end
      q_wr.valid = q_wr.valid && accept;
   end

   // Decoder registers advance on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jsu_pkg::PH_IDLE;
         single_ff <= 1'b0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         bad_ff    <= 1'b0;
         high_ff   <= '0;
         pair_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         single_ff <= single_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         bad_ff    <= bad_in;
         high_ff   <= high_in;
         pair_ff   <= pair_in;
      end
   end

endmodule

[hdl/jsu_queue.sv]
`timescale 1ns / 1ps

module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  jsu_pkg::queue_wr_type   wr,
   input  logic                    pop,
   output jsu_pkg::job_type        rd_job,
   output jsu_pkg::queue_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   jsu_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = wr.valid && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_job     = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

[hdl/jsu_back.sv]
`timescale 1ns / 1ps

module jsu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  jsu_pkg::job_type        q_job,
   input  jsu_pkg::queue_stat_type q_stat,
   output logic                    pop,
   jsu_rsp_if.source               rsp
);

   jsu_pkg::job_type cur_ff, cur_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last;
   logic       beat;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign beat    = valid_ff && rsp.ready;
   assign pop     = !q_stat.empty && (!valid_ff || (beat && at_last));

   // Result beat from the job being played out.
   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = cur_ff.bytes[idx_ff];
   assign rsp.kind     = cur_ff.kind;
   assign rsp.last     = at_last;

   // Load a new job when idle or as the last beat of the current one leaves.
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cur_in   = q_job;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (beat && at_last) begin
         valid_in = 1'b0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
